@@ rtl/lpc_pkg.sv @@
// Package with the codes, types and helpers of the link primary confirm state machine.
package lpc_pkg;

    // Width of the retry counter and of the retry limit register.
    localparam int RETRY_W = 8;

    // Event codes of one input transfer.
    typedef enum logic [2:0] {
        OP_SEND_CONFIRMED   = 3'd0,
        OP_SEND_UNCONFIRMED = 3'd1,
        OP_ACK              = 3'd2,
        OP_NACK             = 3'd3,
        OP_LINK_STATUS      = 3'd4,
        OP_NOT_SUPPORTED    = 3'd5,
        OP_TIMEOUT          = 3'd6,
        OP_FAILURE          = 3'd7
    } opcode_t;

    // Frame to send.
    typedef enum logic [1:0] {
        FR_NONE       = 2'd0,
        FR_UNCONF     = 2'd1,
        FR_RESET_LINK = 2'd2,
        FR_CONF       = 2'd3
    } frame_t;

    // Response timer command.
    typedef enum logic [1:0] {
        TM_NONE    = 2'd0,
        TM_START   = 2'd1,
        TM_CANCEL  = 2'd2,
        TM_RESTART = 2'd3
    } timer_t;

    // Report codes; the three unused codes never occur.
    typedef enum logic [2:0] {
        RP_NONE       = 3'd0,
        RP_SUCCESS    = 3'd1,
        RP_FAILURE    = 3'd2,
        RP_UNEXPECTED = 3'd3,
        RP_INVALID    = 3'd4
    } report_t;

    // Encoded link state as seen on the result port.
    localparam logic [1:0] LS_NOT_RESET    = 2'd0;
    localparam logic [1:0] LS_RESET        = 2'd1;
    localparam logic [1:0] LS_RESET_WAIT   = 2'd2;
    localparam logic [1:0] LS_CONFIRM_WAIT = 2'd3;

    // Internal link state, one-hot.
    typedef enum logic [3:0] {
        ST_NOT_RESET    = 4'b0001,
        ST_RESET        = 4'b0010,
        ST_RESET_WAIT   = 4'b0100,
        ST_CONFIRM_WAIT = 4'b1000
    } pstate_t;

    // State carried from one event to the next.
    typedef struct packed {
        pstate_t              pstate;
        logic                 write_fcb;
        logic [RETRY_W-1:0]   retry_left;
    } link_ctx_t;

    // One result item.
    typedef struct packed {
        frame_t               frame_action;
        logic                 frame_fcb;
        timer_t               timer_command;
        report_t              report;
        logic [1:0]           link_state;
        logic [RETRY_W-1:0]   retries_remaining;
    } result_t;

    // Map the one-hot state to its port encoding.
    function automatic logic [1:0] encode_state(input pstate_t st);
        logic [1:0] code;
        code = LS_NOT_RESET;
        unique case (st)
            ST_NOT_RESET:    code = LS_NOT_RESET;
            ST_RESET:        code = LS_RESET;
            ST_RESET_WAIT:   code = LS_RESET_WAIT;
            ST_CONFIRM_WAIT: code = LS_CONFIRM_WAIT;
            default:         code = LS_NOT_RESET;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/lpc_step.sv @@
// Next-state and result logic for one link event.
module lpc_step (
    input  lpc_pkg::opcode_t                 opcode,
    input  logic                             rcv_buffer_full,
    input  logic [lpc_pkg::RETRY_W-1:0]      max_retries,
    input  lpc_pkg::link_ctx_t               ctx,
    output lpc_pkg::link_ctx_t               ctx_next,
    output lpc_pkg::result_t                 result
);

    logic waiting;
    lpc_pkg::frame_t  frame;
    logic             fcb;
    lpc_pkg::timer_t  tmr;
    lpc_pkg::report_t rep;

    assign waiting = (ctx.pstate == lpc_pkg::ST_RESET_WAIT) ||
                     (ctx.pstate == lpc_pkg::ST_CONFIRM_WAIT);

    // Event decode: everything defaults to no action and unchanged state.
    always_comb begin
        ctx_next = ctx;
        frame    = lpc_pkg::FR_NONE;
        fcb      = 1'b0;
        tmr      = lpc_pkg::TM_NONE;
        rep      = lpc_pkg::RP_NONE;
        unique case (opcode)
            lpc_pkg::OP_SEND_CONFIRMED: begin
                if (ctx.pstate == lpc_pkg::ST_NOT_RESET) begin
                    ctx_next.retry_left = max_retries;
                    ctx_next.pstate     = lpc_pkg::ST_RESET_WAIT;
                    tmr                 = lpc_pkg::TM_START;
                    frame               = lpc_pkg::FR_RESET_LINK;
                end else if (ctx.pstate == lpc_pkg::ST_RESET) begin
                    ctx_next.retry_left = max_retries;
                    ctx_next.pstate     = lpc_pkg::ST_CONFIRM_WAIT;
                    tmr                 = lpc_pkg::TM_START;
                    frame               = lpc_pkg::FR_CONF;
                    fcb                 = ctx.write_fcb;
                end else begin
                    rep = lpc_pkg::RP_INVALID;
                end
            end
            lpc_pkg::OP_SEND_UNCONFIRMED: begin
                if (waiting) begin
                    rep = lpc_pkg::RP_INVALID;
                end else begin
                    frame = lpc_pkg::FR_UNCONF;
                end
            end
            lpc_pkg::OP_ACK: begin
                if (ctx.pstate == lpc_pkg::ST_RESET_WAIT) begin
                    // Link reset confirmed: send the held data frame with FCB set.
                    ctx_next.write_fcb = 1'b1;
                    ctx_next.pstate    = lpc_pkg::ST_CONFIRM_WAIT;
                    tmr                = lpc_pkg::TM_RESTART;
                    frame              = lpc_pkg::FR_CONF;
                    fcb                = 1'b1;
                end else if (ctx.pstate == lpc_pkg::ST_CONFIRM_WAIT) begin
                    ctx_next.write_fcb = ~ctx.write_fcb;
                    ctx_next.pstate    = lpc_pkg::ST_RESET;
                    tmr                = lpc_pkg::TM_CANCEL;
                    rep                = lpc_pkg::RP_SUCCESS;
                end else begin
                    rep = lpc_pkg::RP_UNEXPECTED;
                end
            end
            lpc_pkg::OP_NACK: begin
                if (ctx.pstate == lpc_pkg::ST_CONFIRM_WAIT) begin
                    if (rcv_buffer_full) begin
                        ctx_next.pstate = lpc_pkg::ST_NOT_RESET;
                        tmr             = lpc_pkg::TM_CANCEL;
                        rep             = lpc_pkg::RP_FAILURE;
                    end else begin
                        ctx_next.retry_left = max_retries;
                        ctx_next.pstate     = lpc_pkg::ST_RESET_WAIT;
                        tmr                 = lpc_pkg::TM_RESTART;
                        frame               = lpc_pkg::FR_RESET_LINK;
                    end
                end else begin
                    rep = lpc_pkg::RP_UNEXPECTED;
                end
            end
            lpc_pkg::OP_LINK_STATUS, lpc_pkg::OP_NOT_SUPPORTED: begin
                rep = lpc_pkg::RP_UNEXPECTED;
            end
            lpc_pkg::OP_TIMEOUT: begin
                if (!waiting) begin
                    rep = lpc_pkg::RP_INVALID;
                end else if (ctx.retry_left != '0) begin
                    // Retransmit the frame that is outstanding.
                    ctx_next.retry_left = ctx.retry_left - lpc_pkg::RETRY_W'(1);
                    tmr                 = lpc_pkg::TM_START;
                    if (ctx.pstate == lpc_pkg::ST_RESET_WAIT) begin
                        frame = lpc_pkg::FR_RESET_LINK;
                    end else begin
                        frame = lpc_pkg::FR_CONF;
                        fcb   = ctx.write_fcb;
                    end
                end else begin
                    ctx_next.pstate = lpc_pkg::ST_NOT_RESET;
                    rep             = lpc_pkg::RP_FAILURE;
                end
            end
            lpc_pkg::OP_FAILURE: begin
                if (waiting) begin
                    ctx_next.pstate = lpc_pkg::ST_NOT_RESET;
                    tmr             = lpc_pkg::TM_CANCEL;
                    rep             = lpc_pkg::RP_FAILURE;
                end
            end
            default: begin
                rep = lpc_pkg::RP_NONE;
            end
        endcase
    end

    // Pack the result item.
    always_comb begin
        result.frame_action      = frame;
        result.frame_fcb         = fcb;
        result.timer_command     = tmr;
        result.report            = rep;
        result.link_state        = lpc_pkg::encode_state(ctx_next.pstate);
        result.retries_remaining = ctx_next.retry_left;
    end

endmodule

@@ rtl/link_primary_confirm_fsm.sv @@
// Top level of the link primary confirm state machine: input register, state and result register.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      s_opcode, s_rcv_buffer_full
//   m_       out        m_valid / m_ready      m_frame_action .. m_retries_remaining
//   cfg_     in         cfg_wr_en (no wait)    cfg_wr_data (max_retries)
//
// One event per cycle is sustained while m_ready is high; each input transfer passes
// through the input register, then the state update into the result register.
// The link state is updated in the same cycle that an event moves into the result register.
// Reset (aresetn low, synchronous) returns the link to not reset, FCB 0, retries 0, limit 0.
// When m_ready stays low both registers fill and s_ready drops until a result is taken.
module link_primary_confirm_fsm (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lpc_pkg::RETRY_W-1:0]     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_opcode,
    input  logic                            s_rcv_buffer_full,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_frame_action,
    output logic                            m_frame_fcb,
    output logic [1:0]                      m_timer_command,
    output logic [2:0]                      m_report,
    output logic [1:0]                      m_link_state,
    output logic [lpc_pkg::RETRY_W-1:0]     m_retries_remaining
);

    logic [lpc_pkg::RETRY_W-1:0] max_retries_reg;
    logic                        in_valid_reg;
    lpc_pkg::opcode_t            in_opcode_reg;
    logic                        in_full_reg;
    lpc_pkg::link_ctx_t          ctx_reg;
    lpc_pkg::link_ctx_t          ctx_next;
    logic                        out_valid_reg;
    lpc_pkg::result_t            out_reg;
    lpc_pkg::result_t            result_next;
    logic                        advance;

    // An event advances when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Retry limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg <= '0;
        end else if (cfg_wr_en) begin
            max_retries_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_opcode_reg <= lpc_pkg::opcode_t'(s_opcode);
            in_full_reg   <= s_rcv_buffer_full;
        end
    end

    // Event logic.
    lpc_step u_step (
        .opcode          (in_opcode_reg),
        .rcv_buffer_full (in_full_reg),
        .max_retries     (max_retries_reg),
        .ctx             (ctx_reg),
        .ctx_next        (ctx_next),
        .result          (result_next)
    );

    // Link state, updated as each event passes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.pstate     <= lpc_pkg::ST_NOT_RESET;
            ctx_reg.write_fcb  <= 1'b0;
            ctx_reg.retry_left <= '0;
        end else if (advance) begin
            ctx_reg <= ctx_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_frame_action      = out_reg.frame_action;
    assign m_frame_fcb         = out_reg.frame_fcb;
    assign m_timer_command     = out_reg.timer_command;
    assign m_report            = out_reg.report;
    assign m_link_state        = out_reg.link_state;
    assign m_retries_remaining = out_reg.retries_remaining;

`ifndef SYNTH
    // An event that advances always shows up as a valid result next cycle.
    a_advance_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg
    ) else $error("advanced event did not reach the result register");

    // A timeout with retries left spends exactly one retry.
    a_timeout_decrements: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && in_opcode_reg == lpc_pkg::OP_TIMEOUT &&
         ctx_reg.retry_left != '0 &&
         (ctx_reg.pstate == lpc_pkg::ST_RESET_WAIT ||
          ctx_reg.pstate == lpc_pkg::ST_CONFIRM_WAIT))
        |=> ctx_reg.retry_left == $past(ctx_reg.retry_left) - lpc_pkg::RETRY_W'(1)
    ) else $error("timeout retry count mismatch");

    // The reported link state always matches the stored state after the event.
    a_state_matches: assert property (
        @(posedge aclk) disable iff (!aresetn)
        advance |=> out_reg.link_state == lpc_pkg::encode_state(ctx_reg.pstate)
    ) else $error("reported link state differs from stored state");

    // A confirmed data frame always goes out with the response timer running.
    a_conf_has_timer: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.frame_action == lpc_pkg::FR_CONF) |->
        (out_reg.timer_command == lpc_pkg::TM_START ||
         out_reg.timer_command == lpc_pkg::TM_RESTART)
    ) else $error("confirmed frame without timer start");
`endif

endmodule
